// File: rtl/plsf_pkg.sv
// ----------------------------------------------------------------------------
// plsf_pkg
// Shared types, constants and helper functions of the power-law fit unit.
// ----------------------------------------------------------------------------
package plsf_pkg;

  localparam int COUNT_WIDTH_DEF   = 16;
  localparam int LOG_FRAC_BITS_DEF = 24;

  localparam logic [63:0] LN2_Q63   = 64'h58B90BFBE8E7BCD6;
  localparam logic [63:0] LOG2E_Q62 = 64'h5C551D94AE0BF85E;

  typedef enum logic [1:0] {
    FIT_OK    = 2'd0,
    FIT_DEGEN = 2'd1,
    FIT_BAD   = 2'd2,
    FIT_SAT   = 2'd3
  } fit_status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LN_INIT, S_LN_SQ, S_LN_L2, S_LN_RND,
    S_ACC1, S_ACC2, S_ACC3, S_CHECK,
    S_FIT0, S_FIT1, S_FIT2, S_FIT3, S_FIT4, S_FIT5,
    S_FIT6, S_FIT7, S_FIT8, S_FIT9, S_FIT10,
    S_EXP0, S_EXP1, S_EXP2, S_EXP3, S_EXP4,
    S_MUL, S_DIV, S_DONE
  } state_t;

  // Shifts a product magnitude right by k with rounding half up, then applies the sign.
  function automatic logic [63:0] rnd_shr(input logic [127:0] p, input logic neg,
                                          input logic [6:0] k);
    logic [127:0] h;
    logic [127:0] s;
    logic [63:0]  r;
    h = 128'd1 << (k - 7'd1);
    s = (p + h) >> k;
    r = s[63:0];
    return neg ? (64'd0 - r) : r;
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [127:0] mag128(input logic [127:0] v);
    return v[127] ? (128'd0 - v) : v;
  endfunction

endpackage

// File: rtl/power_law_least_squares_fit_unit.sv
// ----------------------------------------------------------------------------
// power_law_least_squares_fit_unit
// Least-squares fit of y = a * x^b in the log domain, built around one shared
// 32x32 multiplier and one restoring divide step under a microcoded sequencer.
// ----------------------------------------------------------------------------
// Each input word is one (x, y) pair in unsigned Q16.16. An accepted point is
// worked through two logarithms of LOG_FRAC_BITS squarings each on the shared
// multiplier, plus 64x64 products built from four partial products. A word
// marked last then starts the fit, which runs on the bit-serial divider (two
// long divisions and twenty series terms of 64 steps each). in_ready is low
// while a word is being worked on; one result word is held until taken.
module power_law_least_squares_fit_unit
  import plsf_pkg::*;
#(
  parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF,
  parameter int LOG_FRAC_BITS = LOG_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_sample_x,
  input  logic [31:0]        in_sample_y,
  input  logic               in_last_point,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_scale_a,
  output logic signed [31:0] out_exponent_b,
  output logic [1:0]         out_fit_status,
  output logic [15:0]        out_point_count
);

  localparam int FB  = LOG_FRAC_BITS;
  localparam int CW  = COUNT_WIDTH;
  localparam int SQW = $clog2(FB + 1);
  localparam int SH_DN = (FB > 16) ? (FB - 16) : 0;
  localparam int SH_UP = (FB > 16) ? 0 : (16 - FB);
  localparam logic [63:0] M16_RND = (64'd1 << SH_DN) >> 1;
  localparam logic [63:0] BCAP    = 64'd1 << (15 + FB);
  localparam logic [63:0] ACAP    = 64'd32 << FB;
  localparam logic [63:0] FMASK   = (64'd1 << FB) - 64'd1;
  localparam logic [7:0]  IT_B    = 8'(128 + FB);
  localparam logic [7:0]  IT_A    = 8'd128;
  localparam logic [7:0]  IT_T    = 8'd64;
  localparam logic [6:0]  K_FB    = 7'(FB);
  localparam logic [6:0]  K_FB1   = 7'(FB + 1);
  localparam logic [6:0]  K_62    = 7'd62;
  localparam logic [6:0]  K_63    = 7'd63;
  localparam logic [SQW-1:0] SQ_LAST = SQW'(FB - 1);
  localparam logic [4:0]  TERMS   = 5'd20;

  state_t state_r, state_nxt, ret_r, ret_nxt;

  logic [31:0]     x_r, x_nxt, y_r, y_nxt;
  logic            last_r, last_nxt, lnsel_r, lnsel_nxt;
  logic [30:0]     m_r, m_nxt;
  logic [FB-1:0]   f_r, f_nxt;
  logic [SQW-1:0]  sq_r, sq_nxt;
  logic signed [5:0] e_r, e_nxt;
  logic [63:0]     lx_r, lx_nxt, ly_r, ly_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [47:0]     sx_r, sx_nxt, sy_r, sy_nxt;
  logic [63:0]     sxy_r, sxy_nxt, sxx_r, sxx_nxt;
  logic            bad_r, bad_nxt;
  logic [63:0]     ma_r, ma_nxt, mb_r, mb_nxt;
  logic            mneg_r, mneg_nxt;
  logic [127:0]    acc_r, acc_nxt;
  logic [63:0]     pp_r, pp_nxt;
  logic [1:0]      psel_r, psel_nxt;
  logic [2:0]      mcnt_r, mcnt_nxt;
  logic [127:0]    d_r, d_nxt, num_r, num_nxt;
  logic [127:0]    dvd_r, dvd_nxt, dvs_r, dvs_nxt, rem_r, rem_nxt;
  logic [63:0]     q_r, q_nxt, cap_r, cap_nxt;
  logic            big_r, big_nxt;
  logic [7:0]      dit_r, dit_nxt, dcnt_r, dcnt_nxt;
  logic [6:0]      k_r, k_nxt;
  logic [63:0]     yx_r, yx_nxt, ex_r, ex_nxt;
  logic [4:0]      i_r, i_nxt;
  fit_status_t     st_r, st_nxt;
  logic            sat_r, sat_nxt;
  logic [31:0]     ra_r, ra_nxt, rb_r, rb_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [31:0]     out_a_r, out_a_nxt, out_b_r, out_b_nxt;
  fit_status_t     out_st_r, out_st_nxt;
  logic [15:0]     out_cnt_r, out_cnt_nxt;

  logic [31:0]  mul_a, mul_b;
  logic [63:0]  prod;
  logic [31:0]  ln_u;
  logic [4:0]   msb_p;
  logic [31:0]  norm_sh;
  logic [31:0]  sq_val;
  logic [63:0]  l2;
  logic [127:0] sacc;
  logic [63:0]  sx64, sy64, n64, cnt64;
  logic [127:0] thr;
  logic         degen;
  logic [63:0]  qf, m16;
  logic         bsat;
  logic [31:0]  bval;
  logic [63:0]  tt, k64;
  logic         ksat, kzero;
  logic [63:0]  yx_c, term_c;
  logic [6:0]   exp_s;
  logic [63:0]  exp_r;
  logic         rsat;
  logic         div_bit, div_carry, div_ge;
  logic [127:0] div_rs;
  logic [63:0]  div_qn;
  logic [1:0]   psum;
  logic         out_free;
  logic         in_zero, cnt_full;

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_scale_a     = out_a_r;
  assign out_exponent_b  = out_b_r;
  assign out_fit_status  = out_st_r;
  assign out_point_count = out_cnt_r;

  assign out_free = !out_valid_r || out_ready;
  assign in_zero  = (in_sample_x == 32'd0) || (in_sample_y == 32'd0);
  assign cnt_full = &cnt_r;

  // Shared multiplier: squares the log mantissa or forms one 32x32 partial product.
  always_comb begin
    if (state_r == S_LN_SQ) begin
      mul_a = {1'b0, m_r};
      mul_b = {1'b0, m_r};
    end else begin
      mul_a = mcnt_r[1] ? ma_r[63:32] : ma_r[31:0];
      mul_b = mcnt_r[0] ? mb_r[63:32] : mb_r[31:0];
    end
  end
  assign prod = mul_a * mul_b;

  always_comb begin
    ln_u  = lnsel_r ? y_r : x_r;
    msb_p = 5'd0;
    for (int b = 0; b < 32; b++) begin
      if (ln_u[b]) msb_p = 5'(b);
    end
    norm_sh = (msb_p == 5'd31) ? (ln_u >> 1) : (ln_u << (5'd30 - msb_p));
  end

  assign sq_val = prod[61:30];
  assign l2     = ({{58{e_r[5]}}, e_r} << FB) + 64'(f_r);
  assign sacc   = mneg_r ? (128'd0 - acc_r) : acc_r;
  assign sx64   = {{16{sx_r[47]}}, sx_r};
  assign sy64   = {{16{sy_r[47]}}, sy_r};
  assign cnt64  = 64'(cnt_r);
  assign n64    = cnt64;
  assign thr    = acc_r << FB;
  assign degen  = d_r[127] || (thr >= d_r);
  assign qf     = big_r ? cap_r : q_r;

  always_comb begin
    if (FB > 16) m16 = (qf + M16_RND) >> SH_DN;
    else         m16 = qf << SH_UP;
    if (!num_r[127]) begin
      bsat = (m16 > 64'h7FFFFFFF);
      bval = bsat ? 32'h7FFFFFFF : m16[31:0];
    end else begin
      bsat = (m16 > 64'h80000000);
      bval = bsat ? 32'h80000000 : (32'd0 - m16[31:0]);
    end
  end

  assign tt     = rnd_shr(acc_r, mneg_r, K_62);
  assign k64    = $signed(tt) >>> FB;
  assign ksat   = $signed(k64) >= 64'sd16;
  assign kzero  = $signed(k64) <= -64'sd18;
  assign yx_c   = rnd_shr(acc_r, 1'b0, K_FB1);
  assign term_c = rnd_shr(acc_r, 1'b0, K_62);
  assign exp_s  = 7'd46 - k_r;
  assign exp_r  = (ex_r + (64'd1 << (exp_s - 7'd1))) >> exp_s;
  assign rsat   = (exp_r[63:32] != 32'd0);

  assign div_bit   = dvd_r[127];
  assign div_carry = rem_r[127];
  assign div_rs    = {rem_r[126:0], div_bit};
  assign div_ge    = div_carry || (div_rs >= dvs_r);
  assign div_qn    = {q_r[62:0], div_ge};
  assign psum      = {1'b0, psel_r[1]} + {1'b0, psel_r[0]};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_zero || cnt_full) state_nxt = S_CHECK;
          else                     state_nxt = S_LN_INIT;
        end
      end
      S_LN_INIT: state_nxt = S_LN_SQ;
      S_LN_SQ:   if (sq_r == SQ_LAST) state_nxt = S_LN_L2;
      S_LN_L2:   state_nxt = S_MUL;
      S_LN_RND:  state_nxt = lnsel_r ? S_ACC1 : S_LN_INIT;
      S_ACC1:    state_nxt = S_MUL;
      S_ACC2:    state_nxt = S_MUL;
      S_ACC3:    state_nxt = S_CHECK;
      S_CHECK:   state_nxt = last_r ? S_FIT0 : S_IDLE;
      S_FIT0: begin
        if (bad_r || cnt64 < 64'd2) state_nxt = S_DONE;
        else                        state_nxt = S_MUL;
      end
      S_FIT1:  state_nxt = S_MUL;
      S_FIT2:  state_nxt = S_MUL;
      S_FIT3:  state_nxt = degen ? S_DONE : S_MUL;
      S_FIT4:  state_nxt = S_MUL;
      S_FIT5:  state_nxt = S_FIT6;
      S_FIT6:  state_nxt = S_DIV;
      S_FIT7:  state_nxt = S_MUL;
      S_FIT8:  state_nxt = S_FIT9;
      S_FIT9:  state_nxt = S_DIV;
      S_FIT10: state_nxt = S_MUL;
      S_EXP0:  state_nxt = (ksat || kzero) ? S_DONE : S_MUL;
      S_EXP1:  state_nxt = S_MUL;
      S_EXP2:  state_nxt = S_DIV;
      S_EXP3:  state_nxt = (i_r == TERMS) ? S_EXP4 : S_MUL;
      S_EXP4:  state_nxt = S_DONE;
      S_MUL:   if (mcnt_r == 3'd4) state_nxt = ret_r;
      S_DIV:   if (dcnt_r == dit_r - 8'd1) state_nxt = ret_r;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and sequencer outputs.
  always_comb begin
    ret_nxt = ret_r;  x_nxt = x_r;  y_nxt = y_r;  last_nxt = last_r;
    lnsel_nxt = lnsel_r;  m_nxt = m_r;  f_nxt = f_r;  sq_nxt = sq_r;  e_nxt = e_r;
    lx_nxt = lx_r;  ly_nxt = ly_r;  cnt_nxt = cnt_r;  sx_nxt = sx_r;  sy_nxt = sy_r;
    sxy_nxt = sxy_r;  sxx_nxt = sxx_r;  bad_nxt = bad_r;
    ma_nxt = ma_r;  mb_nxt = mb_r;  mneg_nxt = mneg_r;  acc_nxt = acc_r;
    pp_nxt = pp_r;  psel_nxt = psel_r;  mcnt_nxt = mcnt_r;
    d_nxt = d_r;  num_nxt = num_r;  dvd_nxt = dvd_r;  dvs_nxt = dvs_r;  rem_nxt = rem_r;
    q_nxt = q_r;  cap_nxt = cap_r;  big_nxt = big_r;  dit_nxt = dit_r;  dcnt_nxt = dcnt_r;
    k_nxt = k_r;  yx_nxt = yx_r;  ex_nxt = ex_r;  i_nxt = i_r;
    st_nxt = st_r;  sat_nxt = sat_r;  ra_nxt = ra_r;  rb_nxt = rb_r;
    out_valid_nxt = out_valid_r;  out_a_nxt = out_a_r;  out_b_nxt = out_b_r;
    out_st_nxt = out_st_r;  out_cnt_nxt = out_cnt_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        x_nxt = in_sample_x;
        y_nxt = in_sample_y;
        last_nxt = in_last_point;
        lnsel_nxt = 1'b0;
        if (in_valid && in_zero) bad_nxt = 1'b1;
      end
      S_LN_INIT: begin
        m_nxt  = norm_sh[30:0];
        e_nxt  = $signed({1'b0, msb_p}) - 6'sd16;
        f_nxt  = '0;
        sq_nxt = '0;
      end
      S_LN_SQ: begin
        m_nxt  = sq_val[31] ? sq_val[31:1] : sq_val[30:0];
        f_nxt  = {f_r[FB-2:0], sq_val[31]};
        sq_nxt = sq_r + SQW'(1);
      end
      S_LN_L2: begin
        ma_nxt = mag64(l2);  mb_nxt = LN2_Q63;  mneg_nxt = l2[63];
        acc_nxt = '0;  mcnt_nxt = '0;  ret_nxt = S_LN_RND;
      end
      S_LN_RND: begin
        if (lnsel_r) ly_nxt = rnd_shr(acc_r, mneg_r, K_63);
        else         lx_nxt = rnd_shr(acc_r, mneg_r, K_63);
        lnsel_nxt = 1'b1;
      end
      S_ACC1: begin
        sx_nxt  = sx_r + lx_r[47:0];
        sy_nxt  = sy_r + ly_r[47:0];
        cnt_nxt = cnt_r + CW'(1);
        ma_nxt = mag64(lx_r);  mb_nxt = mag64(ly_r);  mneg_nxt = lx_r[63] ^ ly_r[63];
        acc_nxt = '0;  mcnt_nxt = '0;  ret_nxt = S_ACC2;
      end
      S_ACC2: begin
        sxy_nxt = sxy_r + rnd_shr(acc_r, mneg_r, K_FB);
        ma_nxt = mag64(lx_r);  mb_nxt = mag64(lx_r);  mneg_nxt = 1'b0;
        acc_nxt = '0;  mcnt_nxt = '0;  ret_nxt = S_ACC3;
      end
      S_ACC3: begin
        sxx_nxt = sxx_r + rnd_shr(acc_r, mneg_r, K_FB);
      end
      S_CHECK: begin
      end
      S_FIT0: begin
        sat_nxt = 1'b0;
        ra_nxt  = '0;
        rb_nxt  = '0;
        st_nxt  = FIT_OK;
        if (bad_r)                st_nxt = FIT_BAD;
        else if (cnt64 < 64'd2)   st_nxt = FIT_DEGEN;
        ma_nxt = mag64(sxx_r);  mb_nxt = n64;  mneg_nxt = sxx_r[63];
        acc_nxt = '0;  mcnt_nxt = '0;  ret_nxt = S_FIT1;
      end
      S_FIT1: begin
        d_nxt = sacc << FB;
        ma_nxt = mag64(sx64);  mb_nxt = mag64(sx64);  mneg_nxt = 1'b0;
        acc_nxt = '0;  mcnt_nxt = '0;  ret_nxt = S_FIT2;
      end
      S_FIT2: begin
        d_nxt = d_r - acc_r;
        ma_nxt = n64;  mb_nxt = n64;  mneg_nxt = 1'b0;
        acc_nxt = '0;  mcnt_nxt = '0;  ret_nxt = S_FIT3;
      end
      S_FIT3: begin
        if (degen) st_nxt = FIT_DEGEN;
        ma_nxt = mag64(sxy_r);  mb_nxt = n64;  mneg_nxt = sxy_r[63];
        acc_nxt = '0;  mcnt_nxt = '0;  ret_nxt = S_FIT4;
      end
      S_FIT4: begin
        num_nxt = sacc << FB;
        ma_nxt = mag64(sx64);  mb_nxt = mag64(sy64);  mneg_nxt = sx64[63] ^ sy64[63];
        acc_nxt = '0;  mcnt_nxt = '0;  ret_nxt = S_FIT5;
      end
      S_FIT5: begin
        num_nxt = num_r - sacc;
      end
      S_FIT6: begin
        dvd_nxt = mag128(num_r);  dvs_nxt = d_r;  dit_nxt = IT_B;  cap_nxt = BCAP;
        rem_nxt = '0;  q_nxt = '0;  big_nxt = 1'b0;  dcnt_nxt = '0;  ret_nxt = S_FIT7;
      end
      S_FIT7: begin
        rb_nxt  = bval;
        sat_nxt = sat_r | big_r | bsat;
        ma_nxt = qf;  mb_nxt = mag64(sx64);  mneg_nxt = num_r[127] ^ sx64[63];
        acc_nxt = '0;  mcnt_nxt = '0;  ret_nxt = S_FIT8;
      end
      S_FIT8: begin
        num_nxt = ({{64{sy64[63]}}, sy64} << FB) - sacc;
      end
      S_FIT9: begin
        dvd_nxt = mag128(num_r);  dvs_nxt = 128'(n64) << FB;  dit_nxt = IT_A;
        cap_nxt = ACAP;  rem_nxt = '0;  q_nxt = '0;  big_nxt = 1'b0;  dcnt_nxt = '0;
        ret_nxt = S_FIT10;
      end
      S_FIT10: begin
        ma_nxt = qf;  mb_nxt = LOG2E_Q62;  mneg_nxt = num_r[127];
        acc_nxt = '0;  mcnt_nxt = '0;  ret_nxt = S_EXP0;
      end
      S_EXP0: begin
        k_nxt = k64[6:0];
        if (ksat) begin
          sat_nxt = 1'b1;
          ra_nxt  = 32'hFFFFFFFF;
        end else if (kzero) begin
          ra_nxt = '0;
        end
        ma_nxt = tt & FMASK;  mb_nxt = LN2_Q63;  mneg_nxt = 1'b0;
        acc_nxt = '0;  mcnt_nxt = '0;  ret_nxt = S_EXP1;
      end
      S_EXP1: begin
        yx_nxt = yx_c;
        ex_nxt = 64'h4000000000000000;
        i_nxt  = 5'd1;
        ma_nxt = 64'h4000000000000000;  mb_nxt = yx_c;  mneg_nxt = 1'b0;
        acc_nxt = '0;  mcnt_nxt = '0;  ret_nxt = S_EXP2;
      end
      S_EXP2: begin
        dvd_nxt = {term_c, 64'd0};  dvs_nxt = 128'(i_r);  dit_nxt = IT_T;
        cap_nxt = '1;  rem_nxt = '0;  q_nxt = '0;  big_nxt = 1'b0;  dcnt_nxt = '0;
        ret_nxt = S_EXP3;
      end
      S_EXP3: begin
        ex_nxt = ex_r + q_r;
        i_nxt  = i_r + 5'd1;
        ma_nxt = q_r;  mb_nxt = yx_r;  mneg_nxt = 1'b0;
        acc_nxt = '0;  mcnt_nxt = '0;  ret_nxt = S_EXP2;
      end
      S_EXP4: begin
        ra_nxt  = rsat ? 32'hFFFFFFFF : exp_r[31:0];
        sat_nxt = sat_r | rsat;
      end
      S_MUL: begin
        if (mcnt_r != 3'd4) begin
          pp_nxt   = prod;
          psel_nxt = mcnt_r[1:0];
        end
        if (mcnt_r != 3'd0) acc_nxt = acc_r + ({64'd0, pp_r} << {psum, 5'd0});
        mcnt_nxt = mcnt_r + 3'd1;
      end
      S_DIV: begin
        dvd_nxt  = dvd_r << 1;
        rem_nxt  = div_ge ? (div_rs - dvs_r) : div_rs;
        dcnt_nxt = dcnt_r + 8'd1;
        if (!big_r) begin
          q_nxt = div_qn;
          if (div_qn > cap_r) big_nxt = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_a_nxt     = ra_r;
          out_b_nxt     = rb_r;
          out_st_nxt    = (st_r == FIT_OK && sat_r) ? FIT_SAT : st_r;
          out_cnt_nxt   = cnt64[15:0];
          cnt_nxt = '0;  sx_nxt = '0;  sy_nxt = '0;
          sxy_nxt = '0;  sxx_nxt = '0;  bad_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      cnt_r       <= '0;
      sx_r        <= '0;
      sy_r        <= '0;
      sxy_r       <= '0;
      sxx_r       <= '0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
      mcnt_r      <= '0;
      dcnt_r      <= '0;
      sq_r        <= '0;
      i_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      cnt_r       <= cnt_nxt;
      sx_r        <= sx_nxt;
      sy_r        <= sy_nxt;
      sxy_r       <= sxy_nxt;
      sxx_r       <= sxx_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
      mcnt_r      <= mcnt_nxt;
      dcnt_r      <= dcnt_nxt;
      sq_r        <= sq_nxt;
      i_r         <= i_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;  y_r <= y_nxt;  last_r <= last_nxt;  lnsel_r <= lnsel_nxt;
    m_r <= m_nxt;  f_r <= f_nxt;  e_r <= e_nxt;  lx_r <= lx_nxt;  ly_r <= ly_nxt;
    ma_r <= ma_nxt;  mb_r <= mb_nxt;  mneg_r <= mneg_nxt;  acc_r <= acc_nxt;
    pp_r <= pp_nxt;  psel_r <= psel_nxt;  d_r <= d_nxt;  num_r <= num_nxt;
    dvd_r <= dvd_nxt;  dvs_r <= dvs_nxt;  rem_r <= rem_nxt;  q_r <= q_nxt;
    cap_r <= cap_nxt;  big_r <= big_nxt;  dit_r <= dit_nxt;  k_r <= k_nxt;
    yx_r <= yx_nxt;  ex_r <= ex_nxt;  st_r <= st_nxt;  sat_r <= sat_nxt;
    ra_r <= ra_nxt;  rb_r <= rb_nxt;  out_a_r <= out_a_nxt;  out_b_r <= out_b_nxt;
    out_st_r <= out_st_nxt;  out_cnt_r <= out_cnt_nxt;
  end

endmodule

// File: rtl/plsf_checker.sv
// ----------------------------------------------------------------------------
// plsf_checker
// Port-level checks of the power-law fit unit, bound to its top level.
// ----------------------------------------------------------------------------
module plsf_checker
  import plsf_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [31:0]        out_scale_a,
  input logic signed [31:0] out_exponent_b,
  input logic [1:0]         out_fit_status,
  input logic [15:0]        out_point_count
);

  // A result word waiting for the sink holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_scale_a) &&
      $stable(out_exponent_b) && $stable(out_fit_status) && $stable(out_point_count))
    else $error("result word changed while stalled");

  // A failed fit reports zero for both coefficients.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_fit_status == FIT_BAD || out_fit_status == FIT_DEGEN) |->
      out_scale_a == 32'd0 && out_exponent_b == 32'sd0)
    else $error("failed fit with nonzero coefficients");

  // The unit is busy in the cycle after taking a word.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // A new result only appears while the unit is busy.
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");

endmodule

bind power_law_least_squares_fit_unit plsf_checker u_plsf_checker (.*);
